// ----- src/atbs_pkg.sv -----
// ---------------------------------------------------------------------------
// atbs_pkg
// Shared types, codes and index helpers for the array tree / heap store.
// ---------------------------------------------------------------------------
package atbs_pkg;

  localparam int TREE_LEVELS = 4;
  localparam int KEY_WIDTH   = 32;
  localparam int SLOT_COUNT  = (1 << TREE_LEVELS) - 1;
  localparam int IDX_W       = TREE_LEVELS;
  localparam int CNT_W       = TREE_LEVELS;
  localparam int MODE_W      = 2;
  localparam int CMD_W       = 2;
  localparam int STS_W       = 3;
  localparam int IN_KEY_W    = 32;

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [IDX_W:0]              widx_t;
  typedef logic signed [KEY_WIDTH-1:0] key_t;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd2;

  localparam logic [STS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STS_W-1:0] ST_EXISTS   = 3'd2;
  localparam logic [STS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STS_W-1:0] ST_NOSPACE  = 3'd5;

  localparam logic [1:0] WSEL_KEY  = 2'd0;
  localparam logic [1:0] WSEL_RDA  = 2'd1;
  localparam logic [1:0] WSEL_RDB  = 2'd2;
  localparam logic [1:0] WSEL_HOLD = 2'd3;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [IN_KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [CNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic       rd_en;
    idx_t       ra;
    idx_t       rb;
    logic       wr_en;
    idx_t       wa;
    logic [1:0] wsel;
    logic       ld_key;
    logic       ld_hold;
    logic       v_wr_en;
    idx_t       v_wr_idx;
    logic       v_wr_val;
    logic       v_clr_en;
    idx_t       v_clr_idx;
    logic [1:0] cnt_op;
    logic       clr_all;
  } dp_cmd_t;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] valid;
    logic [CNT_W-1:0]      count;
    logic                  heap;
    logic                  eq_a;
    logic                  gt_a;
    logic                  hold_ol;
    logic                  hold_or;
    logic                  a_over_b;
  } dp_sts_t;

  function automatic widx_t left_of(idx_t i);
    return {i, 1'b1};
  endfunction

  function automatic widx_t right_of(idx_t i);
    return widx_t'({i, 1'b1}) + widx_t'(1);
  endfunction

  function automatic idx_t parent_of(idx_t i);
    return (i - idx_t'(1)) >> 1;
  endfunction

  function automatic logic in_range(widx_t w);
    return w < widx_t'(SLOT_COUNT);
  endfunction

endpackage

// ----- src/array_tree_heap_bst_store.sv -----
// ---------------------------------------------------------------------------
// array_tree_heap_bst_store
// Fifteen-slot implicit binary tree of unique signed keys, kept as a search
// tree, a max heap or a min heap.
// ---------------------------------------------------------------------------
// One transaction at a time. Steps that read the key memory go through a
// registered read. Insert: a duplicate scan over all slots, then sift up
// (heap) or descent (search tree). Delete: a scan from the last slot down
// to the match, then for a heap a move of the last entry into the hole plus
// sift down and sift up; for a search tree successor copies and subtree
// lifts. Clear and rejected commands go straight to the result. The result
// sits in an output register, so the next transaction may start while it
// waits.
module array_tree_heap_bst_store import atbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output res_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  atbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  atbs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .key_i       (in_data_i.key),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (dp_sts)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block idle right after accepting a transaction");

  a_no_rd_wr_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.rd_en |-> !dp_cmd.wr_en)
    else $error("key memory read and written in one cycle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_NOSPACE)
    else $error("result carries an undefined status code");

endmodule

// ----- src/atbs_dpath.sv -----
// ---------------------------------------------------------------------------
// atbs_dpath
// Slot key memory, valid flags, entry count, mode register and comparators.
// ---------------------------------------------------------------------------
module atbs_dpath import atbs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic signed [IN_KEY_W-1:0] key_i,
  input  logic                       cfg_we_i,
  input  logic [MODE_W-1:0]          cfg_wdata_i,
  output dp_sts_t                    sts_o
);

  key_t                  mem_q [SLOT_COUNT];
  key_t                  rda_q;
  key_t                  rdb_q;
  key_t                  key_q;
  key_t                  hold_q;
  key_t                  wdata;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [MODE_W-1:0]     mode_q;

  function automatic logic outranks(logic [MODE_W-1:0] m, key_t a, key_t b);
    return (m == MODE_MAX) ? (a > b) : (b > a);
  endfunction

  always_comb begin
    case (cmd_i.wsel)
      WSEL_KEY:  wdata = key_q;
      WSEL_RDA:  wdata = rda_q;
      WSEL_RDB:  wdata = rdb_q;
      default:   wdata = hold_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wa] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rda_q <= mem_q[cmd_i.ra];
      rdb_q <= mem_q[cmd_i.rb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_key) begin
      key_q <= key_t'(key_i);
    end
    if (cmd_i.ld_hold) begin
      hold_q <= rda_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clr_all) begin
      valid_d = '0;
    end
    if (cmd_i.v_wr_en) begin
      valid_d[cmd_i.v_wr_idx] = cmd_i.v_wr_val;
    end
    if (cmd_i.v_clr_en) begin
      valid_d[cmd_i.v_clr_idx] = 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CNT_W'(1);
      CNT_DEC: count_d = count_q - CNT_W'(1);
      CNT_CLR: count_d = '0;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      mode_q  <= MODE_BST;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  assign sts_o.valid    = valid_q;
  assign sts_o.count    = count_q;
  assign sts_o.heap     = (mode_q == MODE_MAX) || (mode_q == MODE_MIN);
  assign sts_o.eq_a     = (rda_q == key_q);
  assign sts_o.gt_a     = (key_q > rda_q);
  assign sts_o.hold_ol  = outranks(mode_q, hold_q, rda_q);
  assign sts_o.hold_or  = outranks(mode_q, hold_q, rdb_q);
  assign sts_o.a_over_b = outranks(mode_q, rda_q, rdb_q);

endmodule

// ----- src/atbs_ctrl.sv -----
// ---------------------------------------------------------------------------
// atbs_ctrl
// Sequencer for insert, delete and clear; owns the slot indices and the
// result register.
// ---------------------------------------------------------------------------
module atbs_ctrl import atbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  req_t    in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output res_t    out_data_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DONE    = 5'd1;
  localparam logic [4:0] S_DUP_RD  = 5'd2;
  localparam logic [4:0] S_DUP_EV  = 5'd3;
  localparam logic [4:0] S_SU_RD   = 5'd4;
  localparam logic [4:0] S_SU_EV   = 5'd5;
  localparam logic [4:0] S_SU_W2   = 5'd6;
  localparam logic [4:0] S_BI_CHK  = 5'd7;
  localparam logic [4:0] S_BI_EV   = 5'd8;
  localparam logic [4:0] S_DEL_RD  = 5'd9;
  localparam logic [4:0] S_DEL_EV  = 5'd10;
  localparam logic [4:0] S_HD_MV   = 5'd11;
  localparam logic [4:0] S_SD_RD   = 5'd12;
  localparam logic [4:0] S_SD_EV   = 5'd13;
  localparam logic [4:0] S_SD_W2   = 5'd14;
  localparam logic [4:0] S_TR      = 5'd15;
  localparam logic [4:0] S_TR_DESC = 5'd16;
  localparam logic [4:0] S_TR_CP   = 5'd17;
  localparam logic [4:0] S_TR_ONE  = 5'd18;
  localparam logic [4:0] S_LF_CHK  = 5'd19;
  localparam logic [4:0] S_LF_MV   = 5'd20;
  localparam logic [4:0] S_LF_NX   = 5'd21;

  logic [4:0]       state_q, state_d;
  idx_t             i_q, i_d;
  idx_t             j_q, j_d;
  idx_t             d_q, d_d;
  idx_t             r_q, r_d;
  logic [STS_W-1:0] code_q, code_d;
  logic             ov_q, ov_d;
  res_t             od_q, od_d;
  dp_cmd_t          dc;

  widx_t lw, rw, jl, dl;
  idx_t  li, ri, pi, pj, pd, last;
  logic  l_ok, vl, vr, take_l;

  assign lw   = left_of(i_q);
  assign rw   = right_of(i_q);
  assign jl   = left_of(j_q);
  assign dl   = left_of(d_q);
  assign li   = idx_t'(lw);
  assign ri   = idx_t'(rw);
  assign pi   = parent_of(i_q);
  assign pj   = parent_of(j_q);
  assign pd   = parent_of(d_q);
  assign last = idx_t'(sts_i.count - CNT_W'(1));
  assign l_ok = in_range(lw);
  assign vl   = l_ok && sts_i.valid[li];
  assign vr   = l_ok && sts_i.valid[ri];
  assign take_l = (vl && vr) ? sts_i.a_over_b : 1'b1;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    d_d     = d_q;
    r_d     = r_q;
    code_d  = code_q;
    ov_d    = ov_q;
    od_d    = od_q;
    dc      = '0;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dc.ld_key = 1'b1;
          code_d    = ST_OK;
          state_d   = S_DONE;
          case (in_data_i.cmd)
            CMD_INSERT: begin
              if (sts_i.count == CNT_W'(SLOT_COUNT)) begin
                code_d = ST_FULL;
              end else begin
                i_d     = '0;
                state_d = S_DUP_RD;
              end
            end
            CMD_DELETE: begin
              if (sts_i.count == '0) begin
                code_d = ST_EMPTY;
              end else begin
                i_d     = idx_t'(SLOT_COUNT - 1);
                state_d = S_DEL_RD;
              end
            end
            CMD_CLEAR: begin
              dc.clr_all = 1'b1;
              dc.cnt_op  = CNT_CLR;
            end
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d             = 1'b1;
          od_d.status      = code_q;
          od_d.entry_count = sts_i.count;
          state_d          = S_IDLE;
        end
      end
      S_DUP_RD: begin
        dc.rd_en = 1'b1;
        dc.ra    = i_q;
        state_d  = S_DUP_EV;
      end
      S_DUP_EV: begin
        if (sts_i.valid[i_q] && sts_i.eq_a) begin
          code_d  = ST_EXISTS;
          state_d = S_DONE;
        end else if (i_q == idx_t'(SLOT_COUNT - 1)) begin
          if (sts_i.heap) begin
            dc.wr_en    = 1'b1;
            dc.wa       = idx_t'(sts_i.count);
            dc.wsel     = WSEL_KEY;
            dc.v_wr_en  = 1'b1;
            dc.v_wr_idx = idx_t'(sts_i.count);
            dc.v_wr_val = 1'b1;
            dc.cnt_op   = CNT_INC;
            i_d         = idx_t'(sts_i.count);
            state_d     = S_SU_RD;
          end else begin
            i_d     = '0;
            state_d = S_BI_CHK;
          end
        end else begin
          i_d     = i_q + idx_t'(1);
          state_d = S_DUP_RD;
        end
      end
      S_SU_RD: begin
        if (i_q == '0 || !sts_i.valid[pi]) begin
          state_d = S_DONE;
        end else begin
          dc.rd_en = 1'b1;
          dc.ra    = i_q;
          dc.rb    = pi;
          j_d      = pi;
          state_d  = S_SU_EV;
        end
      end
      S_SU_EV: begin
        if (sts_i.a_over_b) begin
          dc.wr_en = 1'b1;
          dc.wa    = i_q;
          dc.wsel  = WSEL_RDB;
          state_d  = S_SU_W2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SU_W2: begin
        dc.wr_en = 1'b1;
        dc.wa    = j_q;
        dc.wsel  = WSEL_RDA;
        i_d      = j_q;
        state_d  = S_SU_RD;
      end
      S_BI_CHK: begin
        if (!sts_i.valid[i_q]) begin
          dc.wr_en    = 1'b1;
          dc.wa       = i_q;
          dc.wsel     = WSEL_KEY;
          dc.v_wr_en  = 1'b1;
          dc.v_wr_idx = i_q;
          dc.v_wr_val = 1'b1;
          dc.cnt_op   = CNT_INC;
          state_d     = S_DONE;
        end else begin
          dc.rd_en = 1'b1;
          dc.ra    = i_q;
          state_d  = S_BI_EV;
        end
      end
      S_BI_EV: begin
        if (!in_range(sts_i.gt_a ? rw : lw)) begin
          code_d  = ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          i_d     = sts_i.gt_a ? ri : li;
          state_d = S_BI_CHK;
        end
      end
      S_DEL_RD: begin
        dc.rd_en = 1'b1;
        dc.ra    = i_q;
        state_d  = S_DEL_EV;
      end
      S_DEL_EV: begin
        if (sts_i.valid[i_q] && sts_i.eq_a) begin
          if (sts_i.heap) begin
            dc.rd_en = 1'b1;
            dc.ra    = last;
            j_d      = last;
            state_d  = S_HD_MV;
          end else begin
            state_d = S_TR;
          end
        end else if (i_q == '0) begin
          code_d  = ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          i_d     = i_q - idx_t'(1);
          state_d = S_DEL_RD;
        end
      end
      S_HD_MV: begin
        dc.wr_en     = 1'b1;
        dc.wa        = i_q;
        dc.wsel      = WSEL_RDA;
        dc.ld_hold   = 1'b1;
        dc.v_wr_en   = 1'b1;
        dc.v_wr_idx  = i_q;
        dc.v_wr_val  = sts_i.valid[j_q];
        dc.v_clr_en  = 1'b1;
        dc.v_clr_idx = j_q;
        dc.cnt_op    = CNT_DEC;
        r_d          = i_q;
        if (sts_i.valid[j_q] && (i_q != j_q)) begin
          state_d = S_SD_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SD_RD: begin
        if (!(i_q < idx_t'(sts_i.count)) || !l_ok) begin
          i_d     = r_q;
          state_d = S_SU_RD;
        end else begin
          dc.rd_en = 1'b1;
          dc.ra    = li;
          dc.rb    = ri;
          state_d  = S_SD_EV;
        end
      end
      S_SD_EV: begin
        if ((vl && vr && !(sts_i.hold_ol && sts_i.hold_or)) ||
            (vl && !vr && !sts_i.hold_ol)) begin
          dc.wr_en = 1'b1;
          dc.wa    = i_q;
          dc.wsel  = take_l ? WSEL_RDA : WSEL_RDB;
          j_d      = take_l ? li : ri;
          state_d  = S_SD_W2;
        end else begin
          i_d     = r_q;
          state_d = S_SU_RD;
        end
      end
      S_SD_W2: begin
        dc.wr_en = 1'b1;
        dc.wa    = j_q;
        dc.wsel  = WSEL_HOLD;
        i_d      = j_q;
        state_d  = S_SD_RD;
      end
      S_TR: begin
        if (!vl && !vr) begin
          dc.v_clr_en  = 1'b1;
          dc.v_clr_idx = i_q;
          dc.cnt_op    = CNT_DEC;
          state_d      = S_DONE;
        end else if (vl && vr) begin
          j_d     = ri;
          state_d = S_TR_DESC;
        end else begin
          dc.rd_en = 1'b1;
          dc.ra    = vl ? li : ri;
          j_d      = vl ? li : ri;
          state_d  = S_TR_ONE;
        end
      end
      S_TR_DESC: begin
        if (in_range(jl) && sts_i.valid[idx_t'(jl)]) begin
          j_d = idx_t'(jl);
        end else begin
          dc.rd_en = 1'b1;
          dc.ra    = j_q;
          state_d  = S_TR_CP;
        end
      end
      S_TR_CP: begin
        dc.wr_en = 1'b1;
        dc.wa    = i_q;
        dc.wsel  = WSEL_RDA;
        i_d      = j_q;
        state_d  = S_TR;
      end
      S_TR_ONE: begin
        dc.wr_en     = 1'b1;
        dc.wa        = i_q;
        dc.wsel      = WSEL_RDA;
        dc.v_clr_en  = 1'b1;
        dc.v_clr_idx = j_q;
        dc.cnt_op    = CNT_DEC;
        if (!in_range(jl)) begin
          state_d = S_DONE;
        end else begin
          r_d     = j_q;
          j_d     = idx_t'(jl);
          d_d     = li;
          state_d = S_LF_CHK;
        end
      end
      S_LF_CHK: begin
        if (sts_i.valid[j_q]) begin
          dc.rd_en = 1'b1;
          dc.ra    = j_q;
          state_d  = S_LF_MV;
        end else begin
          state_d = S_LF_NX;
        end
      end
      S_LF_MV: begin
        dc.wr_en     = 1'b1;
        dc.wa        = d_q;
        dc.wsel      = WSEL_RDA;
        dc.v_wr_en   = 1'b1;
        dc.v_wr_idx  = d_q;
        dc.v_wr_val  = 1'b1;
        dc.v_clr_en  = 1'b1;
        dc.v_clr_idx = j_q;
        if (in_range(jl)) begin
          j_d     = idx_t'(jl);
          d_d     = idx_t'(dl);
          state_d = S_LF_CHK;
        end else begin
          state_d = S_LF_NX;
        end
      end
      S_LF_NX: begin
        if (j_q[0]) begin
          j_d     = j_q + idx_t'(1);
          d_d     = d_q + idx_t'(1);
          state_d = S_LF_CHK;
        end else if (pj == r_q) begin
          state_d = S_DONE;
        end else begin
          j_d = pj;
          d_d = pd;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    d_q    <= d_d;
    r_q    <= r_d;
    code_q <= code_d;
    od_q   <= od_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign cmd_o       = dc;

endmodule

// ----- test/atbs_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// atbs_checker
// Watches the request and result channels of the tree / heap store, keeps a
// shadow copy of the slots, predicts status and entry count for every
// accepted request and compares each accepted result in order.
// ---------------------------------------------------------------------------
module atbs_checker import atbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  req_t              in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  res_t              out_data_i,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                done_cnt_o
);

  key_t             shadow_key [SLOT_COUNT];
  logic             shadow_vld [SLOT_COUNT];
  int               shadow_cnt;
  logic [MODE_W-1:0] shadow_mode;
  res_t             res_q [$];

  assign pending_o = res_q.size();

  function automatic logic is_heap();
    return shadow_mode == MODE_MAX || shadow_mode == MODE_MIN;
  endfunction

  function automatic logic outranks(key_t a, key_t b);
    return shadow_mode == MODE_MAX ? (a > b) : (b > a);
  endfunction

  function automatic void swap_slots(int a, int b);
    key_t k;
    logic v;
    k = shadow_key[a]; v = shadow_vld[a];
    shadow_key[a] = shadow_key[b]; shadow_vld[a] = shadow_vld[b];
    shadow_key[b] = k; shadow_vld[b] = v;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i != 0) begin
      p = (i - 1) / 2;
      if (!shadow_vld[p] || !outranks(shadow_key[i], shadow_key[p])) return;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void sift_down(int i);
    int l, r, c;
    while (i < shadow_cnt) begin
      l = 2 * i + 1; r = 2 * i + 2;
      if (l >= SLOT_COUNT) return;
      if (shadow_vld[l] && shadow_vld[r]) begin
        if (outranks(shadow_key[i], shadow_key[l]) &&
            outranks(shadow_key[i], shadow_key[r])) return;
        c = outranks(shadow_key[l], shadow_key[r]) ? l : r;
      end else if (shadow_vld[l] && !outranks(shadow_key[i], shadow_key[l])) begin
        c = l;
      end else begin
        return;
      end
      swap_slots(i, c);
      i = c;
    end
  endfunction

  function automatic void lift(int p, int a, int b);
    if (a >= SLOT_COUNT) return;
    if (shadow_vld[a]) begin
      shadow_key[2*p+1] = shadow_key[a];
      shadow_vld[2*p+1] = 1'b1;
      shadow_vld[a] = 1'b0;
      lift(2*p+1, 2*a+1, 2*a+2);
    end
    if (shadow_vld[b]) begin
      shadow_key[2*p+2] = shadow_key[b];
      shadow_vld[2*p+2] = 1'b1;
      shadow_vld[b] = 1'b0;
      lift(2*p+2, 2*b+1, 2*b+2);
    end
  endfunction

  function automatic void tree_remove(int i);
    int l, r, t, c;
    l = 2 * i + 1; r = 2 * i + 2;
    if (l >= SLOT_COUNT || (!shadow_vld[l] && !shadow_vld[r])) begin
      shadow_vld[i] = 1'b0;
      shadow_cnt--;
    end else if (shadow_vld[l] && shadow_vld[r]) begin
      t = r;
      while (2 * t + 1 < SLOT_COUNT && shadow_vld[2*t+1]) t = 2 * t + 1;
      shadow_key[i] = shadow_key[t];
      tree_remove(t);
    end else begin
      c = shadow_vld[l] ? l : r;
      shadow_key[i] = shadow_key[c];
      shadow_vld[c] = 1'b0;
      lift(i, 2*c+1, 2*c+2);
      shadow_cnt--;
    end
  endfunction

  function automatic logic [STS_W-1:0] insert_key(key_t k);
    int i;
    if (shadow_cnt >= SLOT_COUNT) return ST_FULL;
    for (i = 0; i < SLOT_COUNT; i++)
      if (shadow_vld[i] && shadow_key[i] == k) return ST_EXISTS;
    if (is_heap()) begin
      i = shadow_cnt;
      shadow_key[i] = k; shadow_vld[i] = 1'b1; shadow_cnt++;
      sift_up(i);
      return ST_OK;
    end
    i = 0;
    while (i < SLOT_COUNT) begin
      if (!shadow_vld[i]) begin
        shadow_key[i] = k; shadow_vld[i] = 1'b1; shadow_cnt++;
        return ST_OK;
      end
      i = (k > shadow_key[i]) ? 2 * i + 2 : 2 * i + 1;
    end
    return ST_NOSPACE;
  endfunction

  function automatic logic [STS_W-1:0] delete_key(key_t k);
    int i, last;
    if (shadow_cnt == 0) return ST_EMPTY;
    for (i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!shadow_vld[i] || shadow_key[i] != k) continue;
      if (!is_heap()) begin
        tree_remove(i);
        return ST_OK;
      end
      last = shadow_cnt - 1;
      shadow_key[i] = shadow_key[last];
      shadow_vld[i] = shadow_vld[last];
      shadow_vld[last] = 1'b0;
      shadow_cnt--;
      if (shadow_vld[i]) begin
        sift_down(i);
        sift_up(i);
      end
      return ST_OK;
    end
    return ST_NOTFOUND;
  endfunction

  function automatic res_t predict_result(req_t rq);
    res_t r;
    r.status = ST_OK;
    if (rq.cmd == CMD_INSERT) r.status = insert_key(rq.key);
    else if (rq.cmd == CMD_DELETE) r.status = delete_key(rq.key);
    else if (rq.cmd == CMD_CLEAR) begin
      for (int i = 0; i < SLOT_COUNT; i++) shadow_vld[i] = 1'b0;
      shadow_cnt = 0;
    end
    r.entry_count = shadow_cnt[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        shadow_vld[i] = 1'b0;
        shadow_key[i] = '0;
      end
      shadow_cnt  = 0;
      shadow_mode = MODE_BST;
      res_q.delete();
      fail_cnt_o  = 0;
      done_cnt_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        done_cnt_o++;
        if (res_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_cnt_o++;
        end else begin
          exp_r = res_q.pop_front();
          if (out_data_i.status !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_data_i.status);
            fail_cnt_o++;
          end
          if (out_data_i.entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d actual %0d",
                   exp_r.entry_count, out_data_i.entry_count);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) res_q.push_back(predict_result(in_data_i));
      if (cfg_we_i) shadow_mode = cfg_wdata_i;
    end
  end

endmodule

// ----- test/tb_array_tree_heap_bst_store.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_array_tree_heap_bst_store
// Drives insert, delete and clear transactions into the store in each tree
// mode with random idling on both channels; a checker predicts every result.
// ---------------------------------------------------------------------------
module tb_array_tree_heap_bst_store import atbs_pkg::*; ();

  localparam int WDOG_LIMIT = 4000;

  localparam logic [CMD_W-1:0]  CMD_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  req_t              in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  res_t              out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [MODE_W-1:0] cfg_wdata_i = MODE_BST;
  int                fail_cnt, pending, done_cnt;
  int                idle_cyc = 0;
  logic              quiet = 1'b0;
  key_t              key_pool [16];

  array_tree_heap_bst_store u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  atbs_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .done_cnt_o(done_cnt)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // receiver stall in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 9);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > WDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(logic [CMD_W-1:0] c, key_t k);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{cmd: c, key: k};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_and_set(logic [MODE_W-1:0] m);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic key_t rand_key();
    key_t k;
    k = $urandom;
    return k;
  endfunction

  task automatic random_phase(int n);
    int  r;
    key_t k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? rand_key() : key_pool[$urandom_range(0, 15)];
      if (r < 55) send(CMD_INSERT, k);
      else if (r < 92) send(CMD_DELETE, k);
      else if (r < 96) send(CMD_CLEAR, rand_key());
      else send(CMD_SPARE, k);
    end
  endtask

  initial begin
    logic [MODE_W-1:0] modes [5];
    modes = '{MODE_BST, MODE_MAX, MODE_MIN, MODE_SPARE, MODE_MAX};
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: empty delete, extremes, duplicate, full, no space, clear
    send(CMD_DELETE, 5);
    send(CMD_INSERT, 32'sh8000_0000);
    send(CMD_INSERT, 32'sh7fff_ffff);
    send(CMD_INSERT, 32'sh7fff_ffff);
    send(CMD_DELETE, 17);
    for (int i = 1; i <= 4; i++) send(CMD_INSERT, 32'sh7fff_ffff - i);
    send(CMD_DELETE, 32'sh8000_0000);
    send(CMD_CLEAR, -1);
    send(CMD_SPARE, 0);
    drain_and_set(MODE_MAX);
    for (int i = 0; i < 16; i++) send(CMD_INSERT, i * 3 - 20);
    send(CMD_DELETE, -20);
    send(CMD_DELETE, 25);
    drain_and_set(MODE_MIN);
    send(CMD_INSERT, 100);
    send(CMD_DELETE, 7);
    send(CMD_CLEAR, 0);

    for (int p = 0; p < 5; p++) begin
      drain_and_set(modes[p]);
      if (p == 4) quiet = 1'b1;
      random_phase(240);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d results over search tree, max heap, min heap and mode three",
             done_cnt);
    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- array_tree_heap_bst_store.f -----
src/atbs_pkg.sv
src/atbs_dpath.sv
src/atbs_ctrl.sv
src/array_tree_heap_bst_store.sv
test/atbs_checker.sv
test/tb_array_tree_heap_bst_store.sv
